[rtl/tkmt_pkg.sv]
// ----------------------------------------------------------------------------
// Top-k magnitude tracker package
// Shared types, register map and helpers of the tracker core.
// ----------------------------------------------------------------------------
package tkmt_pkg;

   localparam int ID_W      = 16;
   localparam int DELTA_W   = 32;
   localparam int CNT_OUT_W = 5;
   localparam int CAP_W     = 5;
   localparam int ADDR_W    = 3;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam logic [ADDR_W-1:0] CAP_ADDR  = 3'd0;
   localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;

   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_READOUT = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_CMP0     = 10'b0000000010,
      ST_SRCH     = 10'b0000000100,
      ST_SH_RD    = 10'b0000001000,
      ST_SH_WR    = 10'b0000010000,
      ST_WR_NEW   = 10'b0000100000,
      ST_RO_RD    = 10'b0001000000,
      ST_RO_LD    = 10'b0010000000,
      ST_WAIT     = 10'b0100000000,
      ST_SETUP    = 10'b1000000000
   } state_type;

   function automatic logic [DELTA_W-1:0] mag_of(input logic [DELTA_W-1:0] d);
      return d[DELTA_W-1] ? DELTA_W'(0 - d) : d;
   endfunction

endpackage

[rtl/top_k_magnitude_tracker_core.sv]
// ----------------------------------------------------------------------------
// Top-k magnitude tracker core
// Insert: the slot search, then a move loop that shifts one slot per ST_SH_RD
//   and ST_SH_WR pair on the slot memory (one read port, one write port).
//   Readout gives one entry per pass through ST_RO_RD, ST_RO_LD and ST_WAIT.
// Throughput: one request at a time; req_tready is high only when idle.
// Reset: synchronous; clears held count, capacity to 16, output valid.
// ----------------------------------------------------------------------------
module top_k_magnitude_tracker_core #(
   parameter int MAX_ENTRIES = 16,
   parameter int ID_BITS     = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // entry_id, delta
   input  logic [tkmt_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_type
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // accepted, count, out_id, out_delta, zero pad
   output logic [tkmt_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // entry_valid
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tkmt_pkg::ADDR_W-1:0]           csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import tkmt_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [ID_BITS-1:0] slot_id    [MAX_ENTRIES];
   logic [DELTA_W-1:0] slot_delta [MAX_ENTRIES];

   state_type          st_ff, st_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   tgt_ff, tgt_in;
   logic               up_ff, up_in;
   logic               grow_ff, grow_in;
   logic [ID_BITS-1:0] nid_ff, nid_in;
   logic [DELTA_W-1:0] ndelta_ff, ndelta_in;
   logic [DELTA_W-1:0] nmag_ff, nmag_in;
   logic [ID_BITS-1:0] rd_id_ff;
   logic [DELTA_W-1:0] rd_delta_ff;

   logic               ov_ff, ov_in;
   logic               oacc_ff, oacc_in;
   logic [CNT_OUT_W-1:0] ocnt_ff, ocnt_in;
   logic               oev_ff, oev_in;
   logic [ID_W-1:0]    oid_ff, oid_in;
   logic [DELTA_W-1:0] odelta_ff, odelta_in;
   logic               olast_ff, olast_in;

   logic               we_c;
   logic [AW-1:0]      wa_c;
   logic [AW-1:0]      ra_c;
   logic [ID_BITS-1:0] wd_id_c;
   logic [DELTA_W-1:0] wd_delta_c;

   logic               req_hs, rsp_hs, cfg_wr;
   logic [CMP_W-1:0]   cap0;
   logic               full_c;
   logic [DELTA_W-1:0] mag_rd;

   assign req_hs = req_tvalid && req_tready;
   assign rsp_hs = rsp_tvalid && rsp_tready;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign cap0   = (cap_ff == '0) ? CMP_W'(1) : CMP_W'(cap_ff);
   assign full_c = (CMP_W'(cnt_ff) >= CMP_W'(MAX_ENTRIES)) || (CMP_W'(cnt_ff) >= cap0);
   assign mag_rd = mag_of(rd_delta_ff);

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, odelta_ff, oid_ff, ocnt_ff, oacc_ff};
   assign rsp_tuser  = oev_ff;
   assign rsp_tlast  = olast_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CAP_ADDR) ? 32'(cap_ff) : 32'd0;

   always_comb begin
      logic [CNT_W-1:0] pos;
      logic             setup;
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      tgt_in     = tgt_ff;
      up_in      = up_ff;
      grow_in    = grow_ff;
      nid_in     = nid_ff;
      ndelta_in  = ndelta_ff;
      nmag_in    = nmag_ff;
      ov_in      = ov_ff;
      oacc_in    = oacc_ff;
      ocnt_in    = ocnt_ff;
      oev_in     = oev_ff;
      oid_in     = oid_ff;
      odelta_in  = odelta_ff;
      olast_in   = olast_ff;
      we_c       = 1'b0;
      wa_c       = idx_ff[AW-1:0];
      ra_c       = idx_ff[AW-1:0];
      wd_id_c    = nid_ff;
      wd_delta_c = ndelta_ff;
      pos        = CNT_W'(1);
      setup      = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            ra_c = '0;
            if (req_hs) begin
               nid_in    = ID_BITS'(req_tdata[ID_W-1:0]);
               ndelta_in = req_tdata[ID_W +: DELTA_W];
               nmag_in   = mag_of(req_tdata[ID_W +: DELTA_W]);
               if (req_tuser == REQ_READOUT) begin
                  if (cnt_ff == '0) begin
                     ov_in     = 1'b1;
                     oacc_in   = 1'b0;
                     ocnt_in   = CNT_OUT_W'(cnt_ff);
                     oev_in    = 1'b0;
                     oid_in    = '0;
                     odelta_in = '0;
                     olast_in  = 1'b1;
                     st_in     = ST_WAIT;
                  end else begin
                     idx_in = cnt_ff - CNT_W'(1);
                     st_in  = ST_RO_RD;
                  end
               end else if (cnt_ff == '0) begin
                  // empty store: take it as the only entry
                  we_c       = 1'b1;
                  wa_c       = '0;
                  wd_id_c    = ID_BITS'(req_tdata[ID_W-1:0]);
                  wd_delta_c = req_tdata[ID_W +: DELTA_W];
                  cnt_in     = CNT_W'(1);
                  ov_in      = 1'b1;
                  oacc_in    = 1'b1;
                  ocnt_in    = CNT_OUT_W'(1);
                  oev_in     = 1'b0;
                  oid_in     = '0;
                  odelta_in  = '0;
                  olast_in   = 1'b1;
                  st_in      = ST_WAIT;
               end else begin
                  st_in = ST_CMP0;
               end
            end
         end
         ST_CMP0: begin
            ra_c = AW'(1);
            if (nmag_ff < mag_rd) begin
               if (full_c) begin
                  ov_in     = 1'b1;
                  oacc_in   = 1'b0;
                  ocnt_in   = CNT_OUT_W'(cnt_ff);
                  oev_in    = 1'b0;
                  oid_in    = '0;
                  odelta_in = '0;
                  olast_in  = 1'b1;
                  st_in     = ST_WAIT;
               end else begin
                  idx_in  = cnt_ff;
                  tgt_in  = '0;
                  up_in   = 1'b1;
                  grow_in = 1'b1;
                  st_in   = ST_SH_RD;
               end
            end else if (cnt_ff == CNT_W'(1)) begin
               pos   = CNT_W'(1);
               setup = 1'b1;
            end else begin
               idx_in = CNT_W'(1);
               st_in  = ST_SRCH;
            end
         end
         ST_SRCH: begin
            ra_c = AW'(idx_ff + CNT_W'(1));
            if ((mag_rd < nmag_ff) && ((idx_ff + CNT_W'(1)) < cnt_ff)) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               pos   = (mag_rd < nmag_ff) ? idx_ff + CNT_W'(1) : idx_ff;
               setup = 1'b1;
            end
         end
         ST_SH_RD: begin
            ra_c = up_ff ? AW'(idx_ff - CNT_W'(1)) : AW'(idx_ff + CNT_W'(1));
            st_in = (idx_ff == tgt_ff) ? ST_WR_NEW : ST_SH_WR;
         end
         ST_SH_WR: begin
            we_c       = 1'b1;
            wd_id_c    = rd_id_ff;
            wd_delta_c = rd_delta_ff;
            idx_in     = up_ff ? idx_ff - CNT_W'(1) : idx_ff + CNT_W'(1);
            st_in      = ST_SH_RD;
         end
         ST_WR_NEW: begin
            we_c      = 1'b1;
            cnt_in    = grow_ff ? cnt_ff + CNT_W'(1) : cnt_ff;
            ov_in     = 1'b1;
            oacc_in   = 1'b1;
            ocnt_in   = CNT_OUT_W'(grow_ff ? cnt_ff + CNT_W'(1) : cnt_ff);
            oev_in    = 1'b0;
            oid_in    = '0;
            odelta_in = '0;
            olast_in  = 1'b1;
            st_in     = ST_WAIT;
         end
         ST_RO_RD: begin
            st_in = ST_RO_LD;
         end
         ST_RO_LD: begin
            ov_in     = 1'b1;
            oacc_in   = 1'b0;
            ocnt_in   = CNT_OUT_W'(cnt_ff);
            oev_in    = 1'b1;
            oid_in    = ID_W'(rd_id_ff);
            odelta_in = rd_delta_ff;
            olast_in  = (idx_ff == '0);
            st_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_hs) begin
               ov_in = 1'b0;
               if (olast_ff) begin
                  st_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - CNT_W'(1);
                  st_in  = ST_RO_RD;
               end
            end
         end
         ST_SETUP: begin
            st_in = ST_SH_RD;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (setup) begin
         if (full_c) begin
            // evict the least entry: move the lower run down by one
            idx_in  = '0;
            tgt_in  = pos - CNT_W'(1);
            up_in   = 1'b0;
            grow_in = 1'b0;
         end else begin
            idx_in  = cnt_ff;
            tgt_in  = pos;
            up_in   = 1'b1;
            grow_in = 1'b1;
         end
         st_in = ST_SH_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (we_c) begin
         slot_id[wa_c]    <= wd_id_c;
         slot_delta[wa_c] <= wd_delta_c;
      end
      rd_id_ff    <= slot_id[ra_c];
      rd_delta_ff <= slot_delta[ra_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         cnt_ff <= '0;
         cap_ff <= CAP_RESET;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
         if (cfg_wr && (csr_paddr == CAP_ADDR)) begin
            cap_ff <= csr_pwdata[CAP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      tgt_ff    <= tgt_in;
      up_ff     <= up_in;
      grow_ff   <= grow_in;
      nid_ff    <= nid_in;
      ndelta_ff <= ndelta_in;
      nmag_ff   <= nmag_in;
      oacc_ff   <= oacc_in;
      ocnt_ff   <= ocnt_in;
      oev_ff    <= oev_in;
      oid_ff    <= oid_in;
      odelta_ff <= odelta_in;
      olast_ff  <= olast_in;
   end

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("result pending while idle");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(cnt_ff) <= CMP_W'(MAX_ENTRIES))
      else $error("held count above depth");

   a_cnt_no_shrink: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> cnt_ff >= $past(cnt_ff))
      else $error("held count shrank");

   a_accept_insert_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[0])
      else $error("readout entry flagged as accepted");

endmodule

[verif/top_k_magnitude_tracker_core_test.sv]
// ----------------------------------------------------------------------------
// Top-k magnitude tracker core testbench
// Drives insert and readout requests with random gaps on both stream sides,
// changes the capacity register between phases, and checks every response
// against a sorted-store predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module top_k_magnitude_tracker_core_test;
   import tkmt_pkg::*;

   localparam int SLOTS         = 16;
   localparam int RANDOM_ITEMS  = 100;
   localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [ADDR_W-1:0] NO_REG_ADDR = 3'd4;

   typedef struct packed {
      logic        accepted;
      logic [4:0]  count;
      logic        entry_valid;
      logic [15:0] id;
      logic [31:0] delta;
      logic        last;
   } tracker_result_type;

   class magnitude_scoreboard_type;
      logic [15:0]        kept_id[SLOTS];
      logic [31:0]        kept_delta[SLOTS];
      int unsigned        held;
      logic [4:0]         capacity_reg;
      tracker_result_type pending[$];
      int                 mismatches;

      function new();
         held = 0;
         capacity_reg = CAP_RESET;
         mismatches = 0;
      endfunction

      function void set_capacity(logic [4:0] value);
         capacity_reg = value;
      endfunction

      function int unsigned capacity_now();
         if (capacity_reg == 0) return 1;
         if (capacity_reg > SLOTS) return SLOTS;
         return capacity_reg;
      endfunction

      function logic [31:0] magnitude(logic [31:0] d);
         return d[31] ? (~d + 32'd1) : d;
      endfunction

      function bit place_entry(logic [15:0] id, logic [31:0] d);
         int unsigned cap;
         int unsigned n;
         int unsigned pos;
         int unsigned i;
         logic [31:0] m;
         cap = capacity_now();
         m = magnitude(d);
         n = held;
         if (n == 0) begin
            kept_id[0] = id;
            kept_delta[0] = d;
            held = 1;
            return 1;
         end
         if (m < magnitude(kept_delta[0])) begin
            if (n >= cap) return 0;
            for (i = n; i > 0; i--) begin
               kept_id[i] = kept_id[i-1];
               kept_delta[i] = kept_delta[i-1];
            end
            kept_id[0] = id;
            kept_delta[0] = d;
            held = n + 1;
            return 1;
         end
         pos = 1;
         while (pos < n && magnitude(kept_delta[pos]) < m) pos++;
         if (n >= cap) begin
            // drop the least entry, slide the lower part down
            for (i = 0; i + 1 < pos; i++) begin
               kept_id[i] = kept_id[i+1];
               kept_delta[i] = kept_delta[i+1];
            end
            kept_id[pos-1] = id;
            kept_delta[pos-1] = d;
         end else begin
            for (i = n; i > pos; i--) begin
               kept_id[i] = kept_id[i-1];
               kept_delta[i] = kept_delta[i-1];
            end
            kept_id[pos] = id;
            kept_delta[pos] = d;
            held = n + 1;
         end
         return 1;
      endfunction

      function void note_request(logic req_type, logic [15:0] id, logic [31:0] d);
         tracker_result_type r;
         bit acc;
         int unsigned k;
         r = '0;
         if (req_type == REQ_INSERT) begin
            acc = place_entry(id, d);
            r.accepted = acc;
            r.count = held[4:0];
            r.last = 1'b1;
            pending = {pending, r};
         end else if (held == 0) begin
            r.last = 1'b1;
            pending = {pending, r};
         end else begin
            for (k = 0; k < held; k++) begin
               r.count = held[4:0];
               r.entry_valid = 1'b1;
               r.id = kept_id[held-1-k];
               r.delta = kept_delta[held-1-k];
               r.last = (k + 1 == held);
               pending = {pending, r};
            end
         end
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data, logic user,
                                   logic last_flag);
         tracker_result_type got;
         tracker_result_type want;
         got.accepted = data[0];
         got.count = data[5:1];
         got.id = data[21:6];
         got.delta = data[53:22];
         got.entry_valid = user;
         got.last = last_flag;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: acc=%0d cnt=%0d vld=%0d id=%h d=%h last=%0d",
                        got.accepted, got.count, got.entry_valid, got.id, got.delta,
                        got.last);
            return;
         end
         want = pending.pop_front();
         if (got.accepted !== want.accepted || got.count !== want.count ||
             got.entry_valid !== want.entry_valid || got.id !== want.id ||
             got.delta !== want.delta || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response mismatch at %0t", $realtime);
               $display("  expected acc=%0d cnt=%0d vld=%0d id=%h d=%h last=%0d",
                        want.accepted, want.count, want.entry_valid, want.id,
                        want.delta, want.last);
               $display("  actual   acc=%0d cnt=%0d vld=%0d id=%h d=%h last=%0d",
                        got.accepted, got.count, got.entry_valid, got.id,
                        got.delta, got.last);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [ADDR_W-1:0]      csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   magnitude_scoreboard_type sb = new();
   bit                       quiet_phase;
   int                       cycle_count;
   int                       stall_left;

   top_k_magnitude_tracker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int gap_length();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [31:0] pick_delta();
      int r;
      logic [31:0] d;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 4))
            0: d = 32'h8000_0000;
            1: d = 32'h7FFF_FFFF;
            2: d = 32'h0000_0000;
            3: d = 32'h0000_0001;
            default: d = 32'hFFFF_FFFF;
         endcase
      end else if (r < 3) begin
         d = $urandom_range(0, 8);
      end else begin
         d = $urandom >> $urandom_range(0, 31);
      end
      if ($urandom_range(0, 1) == 1) d = ~d + 32'd1;
      return d;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("top_k_magnitude_tracker_core_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   task automatic send_request(input logic req_type, input logic [15:0] id,
                               input logic [31:0] d);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {d, id};
      req_tuser <= req_type;
      do @(posedge clock); while (!req_tready);
      sb.note_request(req_type, id, d);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == CAP_ADDR) sb.set_capacity(value[4:0]);
   endtask

   task automatic set_capacity(input logic [4:0] cap);
      wait_drained();
      write_register(CAP_ADDR, {27'($urandom_range(0, 32'h07FF_FFFF)), cap});
   endtask

   initial begin
      int sent;
      int n;
      logic [4:0] cap;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= REQ_INSERT;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      quiet_phase = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty store, first entry, then one below the least with room left
      send_request(REQ_READOUT, 16'h0000, 32'h0000_0000);
      send_request(REQ_INSERT, 16'h0000, 32'h0010_0000);
      send_request(REQ_INSERT, 16'hFFFF, 32'h0000_0000);
      send_request(REQ_INSERT, 16'h8000, 32'h8000_0000);
      send_request(REQ_INSERT, 16'h7FFF, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 16'h0001, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 16'h0002, 32'h0000_0001);
      send_request(REQ_INSERT, 16'h0003, 32'hFFF0_0000);
      send_request(REQ_READOUT, 16'hFFFF, 32'hFFFF_FFFF);

      // capacity below the held count: evict, never trim
      set_capacity(5'd3);
      send_request(REQ_INSERT, 16'h0004, 32'h0000_0000);
      send_request(REQ_INSERT, 16'h0005, 32'h0000_0005);
      send_request(REQ_READOUT, 16'h0000, 32'h0000_0000);

      // zero capacity acts as one; full store rejects a smaller entry
      set_capacity(5'd0);
      send_request(REQ_INSERT, 16'h0006, 32'h0000_0000);
      send_request(REQ_INSERT, 16'h0007, 32'h4000_0000);
      send_request(REQ_READOUT, 16'h0000, 32'h0000_0000);

      // oversize capacity clamps to the depth
      set_capacity(5'd31);
      send_request(REQ_INSERT, 16'h0008, 32'hC000_0000);
      send_request(REQ_READOUT, 16'h0000, 32'h0000_0000);
      wait_drained();
      write_register(NO_REG_ADDR, 32'h0000_0001);
      send_request(REQ_INSERT, 16'hAAAA, 32'h5555_5555);
      send_request(REQ_INSERT, 16'h5555, 32'hAAAA_AAAA);
      send_request(REQ_READOUT, 16'h0000, 32'h0000_0000);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: cap = 5'd1;
            1: cap = 5'd16;
            2: cap = 5'd0;
            3: cap = 5'd31;
            default: cap = 5'($urandom_range(0, 31));
         endcase
         set_capacity(cap);
         quiet_phase = ($urandom_range(0, 3) == 0);
         n = $urandom_range(12, 24);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0)
               send_request(REQ_READOUT, 16'($urandom), $urandom);
            else
               send_request(REQ_INSERT, 16'($urandom), pick_delta());
            sent++;
         end
      end

      wait_drained();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("top_k_magnitude_tracker_core_test OK");
      end else begin
         $display("top_k_magnitude_tracker_core_test NOT OK");
      end
      $finish;
   end

endmodule
